/* rtl/bsrch_pkg.sv */
// ----------------------------------------------------------------------------
// bsrch_pkg
// shared constants and types for the sorted table binary search block
// ----------------------------------------------------------------------------
package bsrch_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_KEY_WIDTH   = 32;

  localparam int COUNT_W  = 9;
  localparam int INDEX_W  = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_WRITE_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FOUND      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

endpackage

/* rtl/bsrch_mem.sv */
// ----------------------------------------------------------------------------
// bsrch_mem
// key table: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bsrch_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bsrch_cfg.sv */
// ----------------------------------------------------------------------------
// bsrch_cfg
// apb register file holding entry_count
// ----------------------------------------------------------------------------
module bsrch_cfg
  import bsrch_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output logic [COUNT_W-1:0] entry_count
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_ENTRY_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (wr_en) begin
      entry_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? APB_DW'(entry_count) : '0;

endmodule

/* rtl/bsrch_ctrl.sv */
// ----------------------------------------------------------------------------
// bsrch_ctrl
// item sequencer: table writes and the halving probe loop over the memory
// ----------------------------------------------------------------------------
module bsrch_ctrl
  import bsrch_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
  parameter int IDX_W       = $clog2(TABLE_DEPTH),
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 action,
  input  logic [INDEX_W-1:0]   entry_index,
  input  logic [VALUE_W-1:0]   entry_value,
  input  logic [VALUE_W-1:0]   search_key,
  input  logic [COUNT_W-1:0]   entry_count,
  output logic                 done,
  output logic [STATUS_W-1:0]  status,
  output logic [INDEX_W-1:0]   match_index,
  output logic                 mem_we,
  output logic [IDX_W-1:0]     mem_waddr,
  output logic [KEY_WIDTH-1:0] mem_wdata,
  output logic [IDX_W-1:0]     mem_raddr,
  input  logic [KEY_WIDTH-1:0] mem_rdata
);

  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  state_t               state, state_next;
  logic [IDX_W-1:0]     lo, lo_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [IDX_W-1:0]     probe, probe_next;
  logic [KEY_WIDTH-1:0] key, key_next;
  logic                 done_next;
  logic [STATUS_W-1:0]  status_next;
  logic [INDEX_W-1:0]   match_next;

  logic [CMP_W-1:0]     span_full;
  logic [CNT_W-1:0]     span;
  logic [CNT_W-1:0]     span_half;
  logic [CNT_W-1:0]     probe_sum;
  logic [63:0]          key_ext;
  logic [63:0]          value_ext;
  logic [31:0]          index_ext;
  logic [31:0]          probe_ext;
  logic                 in_range;

  // the search span is entry_count saturated at the table depth
  assign span_full = (CMP_W'(entry_count) > CMP_W'(TABLE_DEPTH)) ?
                     CMP_W'(TABLE_DEPTH) : CMP_W'(entry_count);
  assign span      = span_full[CNT_W-1:0];
  assign span_half = span >> 1;

  assign key_ext   = 64'(search_key);
  assign value_ext = 64'(entry_value);
  assign index_ext = 32'(entry_index);
  assign probe_ext = 32'(probe);
  assign in_range  = index_ext < 32'(TABLE_DEPTH);

  assign mem_waddr = index_ext[IDX_W-1:0];
  assign mem_wdata = value_ext[KEY_WIDTH-1:0];
  assign mem_raddr = probe_next;
  assign busy      = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    lo_next     = lo;
    cnt_next    = cnt;
    probe_next  = probe;
    key_next    = key;
    done_next   = 1'b0;
    status_next = status;
    match_next  = match_index;
    mem_we      = 1'b0;
    probe_sum   = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (action == ACT_WRITE) begin
            mem_we      = in_range;
            done_next   = 1'b1;
            status_next = STAT_WRITE_DONE;
            match_next  = '0;
          end else begin
            key_next   = key_ext[KEY_WIDTH-1:0];
            lo_next    = '0;
            cnt_next   = span;
            probe_next = span_half[IDX_W-1:0];
            if (span == '0) begin
              done_next   = 1'b1;
              status_next = STAT_NOT_FOUND;
              match_next  = '0;
            end else begin
              state_next = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        // mem_rdata holds the entry at probe
        if (mem_rdata == key) begin
          state_next  = ST_IDLE;
          done_next   = 1'b1;
          status_next = STAT_FOUND;
          match_next  = probe_ext[INDEX_W-1:0];
        end else if (cnt == CNT_W'(1)) begin
          state_next  = ST_IDLE;
          done_next   = 1'b1;
          status_next = STAT_NOT_FOUND;
          match_next  = '0;
        end else begin
          if (key < mem_rdata) begin
            cnt_next = cnt >> 1;
          end else begin
            lo_next  = probe;
            cnt_next = cnt - (cnt >> 1);
          end
          // next probe goes straight to the read port
          probe_sum  = CNT_W'(lo_next) + (cnt_next >> 1);
          probe_next = probe_sum[IDX_W-1:0];
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    lo          <= lo_next;
    cnt         <= cnt_next;
    probe       <= probe_next;
    key         <= key_next;
    status      <= status_next;
    match_index <= match_next;
  end

endmodule

/* rtl/sorted_table_binary_search.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// table of ascending unsigned keys with indexed writes and binary search
// ----------------------------------------------------------------------------
//  channel   handshake                      payload
//  input     start / busy                   action, entry_index, entry_value,
//                                           search_key
//  result    done (one-cycle strobe)        status, match_index
//  config    apb psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  for a write item the table is written at the accepting edge and done
//  strobes in the next cycle, while busy stays low.
//  a search item probes up to ceil(log2(n)) + 1 entries for n searched
//  entries (9 for 256), and done strobes in the cycle after the last probe;
//  the single read port of the key table gives one probe per cycle.
//  busy is high while probing; results cannot be stalled by the receiver.
//  rst is synchronous; the key table has no reset and reads of entries
//  never written are undefined.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
  import bsrch_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                action,
  input  logic [INDEX_W-1:0]  entry_index,
  input  logic [VALUE_W-1:0]  entry_value,
  input  logic [VALUE_W-1:0]  search_key,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [INDEX_W-1:0]  match_index,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [COUNT_W-1:0]   entry_count;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic [KEY_WIDTH-1:0] mem_rdata;

  bsrch_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .entry_count (entry_count)
  );

  bsrch_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .search_key  (search_key),
    .entry_count (entry_count),
    .done        (done),
    .status      (status),
    .match_index (match_index),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  bsrch_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KEY_WIDTH),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* rtl/bsrch_checker.sv */
// ----------------------------------------------------------------------------
// bsrch_checker
// port-level checks on the search block, bound to the top level
// ----------------------------------------------------------------------------
module bsrch_checker
  import bsrch_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                action,
  input logic                done,
  input logic [STATUS_W-1:0] status,
  input logic [INDEX_W-1:0]  match_index
);

  // a result never shows while a search is still probing
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // a write item is acknowledged in the very next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_WRITE) |=> (done && status == STAT_WRITE_DONE))
    else $error("write item not acknowledged");

  // an accepted search either finishes at once or keeps the block busy
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_SEARCH) |=> (done || busy))
    else $error("search item dropped");

  // leaving the probe loop always delivers a result
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("search ended without a result");

  // only a found key carries an index
  assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_FOUND) |-> (match_index == '0))
    else $error("index reported without a match");

endmodule

bind sorted_table_binary_search bsrch_checker u_bsrch_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .action      (action),
  .done        (done),
  .status      (status),
  .match_index (match_index)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted table binary search block: loads and
// updates the key table, runs lookups under several entry counts with random
// start gaps, and compares every done strobe against a halving-loop predictor
// ----------------------------------------------------------------------------
module tb_top;
  import bsrch_pkg::*;

  localparam int TBL_DEPTH   = DEF_TABLE_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 100;

  localparam logic [APB_AW-1:0] ADDR_COUNT = {REG_ENTRY_COUNT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_SPARE = {~REG_ENTRY_COUNT, 2'b00};

  typedef struct {
    logic               action;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] key;
  } table_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
  } lookup_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                action = ACT_WRITE;
  logic [INDEX_W-1:0]  entry_index = '0;
  logic [VALUE_W-1:0]  entry_value = '0;
  logic [VALUE_W-1:0]  search_key = '0;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  match_index;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  table_cmd_t    pending_cmds[$];
  lookup_reply_t expected_replies[$];
  table_cmd_t    cur_cmd;

  // predictor state and the generator's view of the table
  logic [VALUE_W-1:0] key_mirror[TBL_DEPTH];
  logic [VALUE_W-1:0] plan_table[TBL_DEPTH];
  logic [COUNT_W-1:0] count_reg = '0;

  int idle_pct = 34;
  int fail_count = 0;
  int cycle_count = 0;

  sorted_table_binary_search DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .entry_index(entry_index), .entry_value(entry_value), .search_key(search_key),
    .done(done), .status(status), .match_index(match_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic lookup_reply_t predict_reply(table_cmd_t c);
    lookup_reply_t r;
    int unsigned base;
    int unsigned span;
    int unsigned probe;
    r.status = STAT_NOT_FOUND;
    r.index  = '0;
    if (c.action == ACT_WRITE) begin
      key_mirror[c.idx] = c.value;
      r.status = STAT_WRITE_DONE;
      return r;
    end
    base = 0;
    span = (count_reg > TBL_DEPTH) ? TBL_DEPTH : count_reg;
    while (span > 0) begin
      probe = base + span / 2;
      if (c.key == key_mirror[probe]) begin
        r.status = STAT_FOUND;
        r.index  = INDEX_W'(probe);
        return r;
      end
      if (span == 1) break;
      if (c.key < key_mirror[probe]) begin
        span = span / 2;
      end else begin
        base = probe;
        span = span - span / 2;
      end
    end
    return r;
  endfunction

  // driver: holds an item on the inputs until start meets busy low
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_replies.push_back(predict_reply(cur_cmd));
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_cmd = pending_cmds.pop_front();
          start       <= 1'b1;
          action      <= cur_cmd.action;
          entry_index <= cur_cmd.idx;
          entry_value <= cur_cmd.value;
          search_key  <= cur_cmd.key;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lookup_reply_t want;
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result: status %0d match_index %0d", status, match_index);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (match_index !== want.index) begin
          $error("match_index: expected %0d, got %0d", want.index, match_index);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_replies.size() != 0);
  endtask

  // register write over apb, only once the block has gone quiet
  task automatic config_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    wait_drained();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == REG_ENTRY_COUNT) count_reg = data[COUNT_W-1:0];
  endtask

  task automatic queue_write(input int unsigned idx, input logic [VALUE_W-1:0] value);
    table_cmd_t c;
    c.action = ACT_WRITE;
    c.idx    = INDEX_W'(idx);
    c.value  = value;
    c.key    = $urandom;
    plan_table[idx] = value;
    pending_cmds.push_back(c);
  endtask

  task automatic queue_search(input logic [VALUE_W-1:0] key);
    table_cmd_t c;
    c.action = ACT_SEARCH;
    c.idx    = INDEX_W'($urandom);
    c.value  = $urandom;
    c.key    = key;
    pending_cmds.push_back(c);
  endtask

  // value keeping idx ascending, unless noisy or neighbours out of order
  function automatic logic [VALUE_W-1:0] pick_value(int unsigned idx, bit noisy);
    logic [VALUE_W-1:0] lo = (idx == 0) ? '0 : plan_table[idx-1];
    logic [VALUE_W-1:0] hi = (idx == TBL_DEPTH - 1) ? '1 : plan_table[idx+1];
    logic [63:0] r = {$urandom, $urandom};
    if (noisy || lo > hi) return $urandom;
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return lo + VALUE_W'(r % (64'(hi) - 64'(lo) + 64'd1));
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_key(int unsigned n);
    int unsigned roll = $urandom_range(0, 99);
    int unsigned top = (n == 0) ? TBL_DEPTH - 1 : n - 1;
    logic [VALUE_W-1:0] k = plan_table[$urandom_range(0, top)];
    if (roll < 50) return k;
    if (roll < 70) return $urandom_range(0, 1) ? k + 1 : k - 1;
    if (roll < 85) return $urandom;
    return $urandom_range(0, 1) ? '0 : '1;
  endfunction

  initial begin
    int unsigned step_val;
    int unsigned cnt;
    int unsigned n;
    int unsigned idx;
    int count_picks[7] = '{0, 1, 2, 3, 256, 511, 300};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // zero count: no probe happens, so the empty table is safe to search
    wait_drained();
    queue_search($urandom);

    // load an ascending table, gaps of at least two so misses exist
    step_val = $urandom_range(1, 1000);
    for (int i = 0; i < TBL_DEPTH - 1; i++) begin
      queue_write(i, step_val);
      step_val += $urandom_range(2, 24'hFF_0000);
    end
    queue_write(TBL_DEPTH - 1, 32'hFFFF_FFFE);

    config_write(ADDR_COUNT, 32'd256);
    queue_search(plan_table[128]);
    queue_search(plan_table[0]);
    queue_search(plan_table[255]);
    queue_search(plan_table[64]);
    queue_search(32'h0);
    queue_search(32'hFFFF_FFFF);
    queue_search(plan_table[37] + 1);
    // duplicate keys, then one entry out of order
    queue_write(10, plan_table[9]);
    queue_search(plan_table[9]);
    queue_write(200, 32'h0);
    queue_search(32'h0);
    queue_search(plan_table[199]);
    queue_write(200, plan_table[199] + 1);

    config_write(ADDR_COUNT, 32'd1);
    queue_search(plan_table[0]);
    queue_search(plan_table[0] + 1);

    // all-ones data: count field reads 511 and saturates
    config_write(ADDR_COUNT, 32'hFFFF_FFFF);
    queue_search(plan_table[255]);
    queue_search(plan_table[1]);

    config_write(ADDR_SPARE, 32'd3);
    queue_search(plan_table[3]);

    config_write(ADDR_COUNT, 32'd2);
    queue_search(plan_table[1]);
    queue_search(plan_table[0]);
    config_write(ADDR_COUNT, 32'd3);
    queue_search(plan_table[2]);
    queue_search(plan_table[0]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 7) begin
        cnt = count_picks[ph];
      end else if ($urandom_range(0, 1)) begin
        cnt = $urandom_range(4, 31);
      end else begin
        cnt = $urandom_range(1, 511);
      end
      if ($urandom_range(0, 3) == 0) config_write(ADDR_SPARE, $urandom);
      config_write(ADDR_COUNT, {23'($urandom_range(0, 32'h7F_FFFF)), COUNT_W'(cnt)});
      n = (cnt > TBL_DEPTH) ? TBL_DEPTH : cnt;
      idle_pct = (ph == 4) ? 0 : 34;

      // put the table back in ascending order after noisy phases
      for (int i = 1; i < TBL_DEPTH; i++) begin
        if (plan_table[i] < plan_table[i-1]) queue_write(i, plan_table[i-1]);
      end

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && ph == 6) wait_drained();
        if ($urandom_range(0, 99) < 30) begin
          if (n > 0 && $urandom_range(0, 9) < 7) idx = $urandom_range(0, n - 1);
          else idx = $urandom_range(0, TBL_DEPTH - 1);
          queue_write(idx, pick_value(idx, (ph % 4 == 3) && $urandom_range(0, 9) == 0));
        end else begin
          queue_search(pick_key(n));
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bsrch_pkg.sv
rtl/bsrch_mem.sv
rtl/bsrch_cfg.sv
rtl/bsrch_ctrl.sv
rtl/sorted_table_binary_search.sv
rtl/bsrch_checker.sv
tb/tb_top.sv
